>>> sv/nbsu_pkg.sv
// Shared definitions for the Neumann boundary stencil update core.
// Holds width defaults, the fixed-point weight offset and the divider tag type.
// No dependencies.
package nbsu_pkg;

   // Default widths of the solution values and normal components.
   localparam int VALUE_WIDTH_DEFAULT  = 22;
   localparam int NORMAL_WIDTH_DEFAULT = 16;

   // Normals carry 14 fraction bits, so one third scaled by 3 * 2^14 is 2^14.
   localparam int NORMAL_FRAC_BITS = 14;
   localparam int ONE_THIRD_SCALED = 1 << NORMAL_FRAC_BITS;

   // Side information that travels with an item through the divider.
   typedef struct packed {
      logic ok;    // boundary voxel with a neighbor on every axis
      logic neg;   // weighted sum was negative
   } nbsu_tag_type;

endpackage

>>> sv/nbsu_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
// Computes floor(num / den) for quotients that fit in QUO_WIDTH bits.
// Depends on nbsu_pkg for the tag type.
module nbsu_div #(
   parameter int QUO_WIDTH = 22,
   parameter int REM_WIDTH = 47,
   parameter int DEN_WIDTH = 21
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic [REM_WIDTH-1:0]  in_num,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  nbsu_pkg::nbsu_tag_type in_tag,
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic [QUO_WIDTH-1:0]  out_quo,
   output nbsu_pkg::nbsu_tag_type out_tag
);
   import nbsu_pkg::*;

   // Stage registers; stage i decides quotient bit QUO_WIDTH-1-i.
   logic [QUO_WIDTH-1:0] vld_ff;
   logic [REM_WIDTH-1:0] rem_ff [QUO_WIDTH];
   logic [DEN_WIDTH-1:0] den_ff [QUO_WIDTH];
   logic [QUO_WIDTH-1:0] quo_ff [QUO_WIDTH];
   nbsu_tag_type         tag_ff [QUO_WIDTH];

   // A stage loads when it is empty or when the stage after it loads.
   logic [QUO_WIDTH:0] load;
   assign load[QUO_WIDTH] = out_ready;

   for (genvar i = 0; i < QUO_WIDTH; i++) begin : g_stage
      localparam int SHIFT = QUO_WIDTH - 1 - i;

      logic                 vld_prev;
      logic [REM_WIDTH-1:0] rem_prev;
      logic [DEN_WIDTH-1:0] den_prev;
      logic [QUO_WIDTH-1:0] quo_prev;
      nbsu_tag_type         tag_prev;
      logic [REM_WIDTH-1:0] trial;
      logic                 take;
      logic [REM_WIDTH-1:0] rem_in;
      logic [QUO_WIDTH-1:0] quo_in;

      if (i == 0) begin : g_first
         assign vld_prev = in_valid;
         assign rem_prev = in_num;
         assign den_prev = in_den;
         assign quo_prev = '0;
         assign tag_prev = in_tag;
      end else begin : g_next
         assign vld_prev = vld_ff[i-1];
         assign rem_prev = rem_ff[i-1];
         assign den_prev = den_ff[i-1];
         assign quo_prev = quo_ff[i-1];
         assign tag_prev = tag_ff[i-1];
      end

      assign load[i] = !vld_ff[i] || load[i+1];

      // Compare against the divisor aligned to this quotient bit.
      assign trial  = {{(REM_WIDTH-DEN_WIDTH){1'b0}}, den_prev} << SHIFT;
      assign take   = (rem_prev >= trial);
      assign rem_in = take ? (rem_prev - trial) : rem_prev;
      assign quo_in = {quo_prev[QUO_WIDTH-2:0], take};

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (load[i]) begin
            vld_ff[i] <= vld_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (load[i]) begin
            rem_ff[i] <= rem_in;
            den_ff[i] <= den_prev;
            quo_ff[i] <= quo_in;
            tag_ff[i] <= tag_prev;
         end
      end
   end

   assign in_ready  = load[0];
   assign out_valid = vld_ff[QUO_WIDTH-1];
   assign out_quo   = quo_ff[QUO_WIDTH-1];
   assign out_tag   = tag_ff[QUO_WIDTH-1];

   // For a valid item whose tag is ok, the final remainder is below the divisor.
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[QUO_WIDTH-1] && tag_ff[QUO_WIDTH-1].ok) |->
      (rem_ff[QUO_WIDTH-1] < {{(REM_WIDTH-DEN_WIDTH){1'b0}}, den_ff[QUO_WIDTH-1]}))
      else $error("divider remainder not below divisor");

   // A finished item that is not taken stays in the last stage.
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (out_valid && !out_ready) |=> out_valid)
      else $error("divider dropped a stalled item");

   // An empty first stage always accepts.
   a_first_free: assert property (@(posedge clock) disable iff (reset)
      !vld_ff[0] |-> in_ready)
      else $error("divider refused an item with an empty first stage");

endmodule

>>> sv/neumann_boundary_stencil_update_core.sv
// Neumann boundary stencil update. For each voxel the core picks one neighbor
// per axis (minus side first when the normal component is positive, plus side
// first otherwise, falling back to the other side) and returns the average of
// the three picks weighted by 1/3 + |n_i|, rounded to nearest with ties away
// from zero. A voxel that is not on the boundary, or that lacks a neighbor on
// some axis, returns 0 with update_valid low. Every accepted item gives one
// result item, in order. The core takes one item per cycle while the result
// side does not stall. The pipeline has four stages for neighbor selection,
// weighting, summing and divide setup, one stage per quotient bit in the
// pipelined long divider, and the output register. Stalls on the result side
// back up stage by stage, and empty stages keep taking items.
// Depends on nbsu_pkg and nbsu_div.
module neumann_boundary_stencil_update_core #(
   parameter int VALUE_WIDTH  = nbsu_pkg::VALUE_WIDTH_DEFAULT,
   parameter int NORMAL_WIDTH = nbsu_pkg::NORMAL_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_is_boundary,
   input  logic [5:0]                     req_neighbor_present,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_x_minus,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_x_plus,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_y_minus,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_y_plus,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_z_minus,
   input  logic signed [VALUE_WIDTH-1:0]  req_value_z_plus,
   input  logic signed [NORMAL_WIDTH-1:0] req_normal_x,
   input  logic signed [NORMAL_WIDTH-1:0] req_normal_y,
   input  logic signed [NORMAL_WIDTH-1:0] req_normal_z,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [VALUE_WIDTH-1:0]  rsp_update_value,
   output logic                           rsp_update_valid
);
   import nbsu_pkg::*;

   // Weight 2^14 + 3*|n| needs two bits over the wider of the normal width and the fraction bits.
   localparam int WGT_WIDTH  = ((NORMAL_WIDTH > NORMAL_FRAC_BITS) ?
                                NORMAL_WIDTH : NORMAL_FRAC_BITS) + 2;
   localparam int PROD_WIDTH = VALUE_WIDTH + WGT_WIDTH + 1;
   localparam int NUM_WIDTH  = PROD_WIDTH + 2;
   localparam int DEN_WIDTH  = WGT_WIDTH + 2;
   localparam int REM_WIDTH  = NUM_WIDTH + 2;
   localparam int DIV_WIDTH  = DEN_WIDTH + 1;

   // Stage registers.
   logic                          s1_vld_ff;
   logic                          s1_ok_ff;
   logic signed [VALUE_WIDTH-1:0] s1_val_ff [3];
   logic [WGT_WIDTH-1:0]          s1_wgt_ff [3];
   logic                          s2_vld_ff;
   logic                          s2_ok_ff;
   logic signed [PROD_WIDTH-1:0]  s2_prod_ff [3];
   logic [DEN_WIDTH-1:0]          s2_den_ff;
   logic                          s3_vld_ff;
   logic                          s3_ok_ff;
   logic signed [NUM_WIDTH-1:0]   s3_num_ff;
   logic [DEN_WIDTH-1:0]          s3_den_ff;
   logic                          s4_vld_ff;
   nbsu_tag_type                  s4_tag_ff;
   logic [REM_WIDTH-1:0]          s4_num_ff;
   logic [DIV_WIDTH-1:0]          s4_den_ff;
   logic                          out_vld_ff;
   logic                          out_ok_ff;
   logic signed [VALUE_WIDTH-1:0] out_val_ff;

   // Next values.
   logic                          s1_ok_in;
   logic signed [VALUE_WIDTH-1:0] s1_val_in [3];
   logic [WGT_WIDTH-1:0]          s1_wgt_in [3];
   logic signed [PROD_WIDTH-1:0]  s2_prod_in [3];
   logic [DEN_WIDTH-1:0]          s2_den_in;
   logic signed [NUM_WIDTH-1:0]   s3_num_in;
   nbsu_tag_type                  s4_tag_in;
   logic [REM_WIDTH-1:0]          s4_num_in;
   logic [DIV_WIDTH-1:0]          s4_den_in;
   logic signed [VALUE_WIDTH-1:0] out_val_in;

   // Load enables: a stage loads when empty or when its successor loads.
   logic s1_load, s2_load, s3_load, s4_load, out_load;
   logic div_in_ready;
   logic div_out_valid;
   logic [VALUE_WIDTH-1:0] div_quo;
   nbsu_tag_type           div_tag;

   assign out_load  = !out_vld_ff || rsp_ready;
   assign s4_load   = !s4_vld_ff || div_in_ready;
   assign s3_load   = !s3_vld_ff || s4_load;
   assign s2_load   = !s2_vld_ff || s3_load;
   assign s1_load   = !s1_vld_ff || s2_load;
   assign req_ready = s1_load;

   // Stage 1: pick a neighbor per axis and form its weight.
   always_comb begin
      logic signed [VALUE_WIDTH-1:0]  val_minus [3];
      logic signed [VALUE_WIDTH-1:0]  val_plus [3];
      logic signed [NORMAL_WIDTH-1:0] nrm [3];
      logic                           pos;
      logic                           use_plus;
      logic                           found;
      logic [NORMAL_WIDTH-1:0]        mag;
      logic [WGT_WIDTH-1:0]           mag_ext;

      val_minus[0] = req_value_x_minus;
      val_minus[1] = req_value_y_minus;
      val_minus[2] = req_value_z_minus;
      val_plus[0]  = req_value_x_plus;
      val_plus[1]  = req_value_y_plus;
      val_plus[2]  = req_value_z_plus;
      nrm[0]       = req_normal_x;
      nrm[1]       = req_normal_y;
      nrm[2]       = req_normal_z;
      s1_ok_in     = req_is_boundary;
      for (int a = 0; a < 3; a++) begin
         pos      = !nrm[a][NORMAL_WIDTH-1] && (nrm[a] != '0);
         found    = req_neighbor_present[2*a] || req_neighbor_present[2*a+1];
         use_plus = pos ? !req_neighbor_present[2*a] : req_neighbor_present[2*a+1];
         s1_val_in[a] = use_plus ? val_plus[a] : val_minus[a];
         // The most negative code wraps to its exact magnitude as unsigned.
         mag      = nrm[a][NORMAL_WIDTH-1] ? NORMAL_WIDTH'(-nrm[a]) : NORMAL_WIDTH'(nrm[a]);
         mag_ext  = WGT_WIDTH'(mag);
         s1_wgt_in[a] = WGT_WIDTH'(ONE_THIRD_SCALED) + mag_ext + (mag_ext << 1);
         s1_ok_in = s1_ok_in && found;
      end
   end

   // Stage 2: one product per axis and the weight sum.
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         s2_prod_in[a] = s1_val_ff[a] * $signed({1'b0, s1_wgt_ff[a]});
      end
      s2_den_in = DEN_WIDTH'(s1_wgt_ff[0]) + DEN_WIDTH'(s1_wgt_ff[1]) +
                  DEN_WIDTH'(s1_wgt_ff[2]);
   end

   // Stage 3: weighted sum.
   assign s3_num_in = NUM_WIDTH'(s2_prod_ff[0]) + NUM_WIDTH'(s2_prod_ff[1]) +
                      NUM_WIDTH'(s2_prod_ff[2]);

   // Stage 4: rounding setup, q = floor((2|num| + den) / (2 den)).
   always_comb begin
      logic [NUM_WIDTH-1:0] mag;

      s4_tag_in.ok  = s3_ok_ff;
      s4_tag_in.neg = s3_num_ff[NUM_WIDTH-1];
      mag           = s4_tag_in.neg ? NUM_WIDTH'(-s3_num_ff) : NUM_WIDTH'(s3_num_ff);
      s4_num_in     = {1'b0, mag, 1'b0} + REM_WIDTH'(s3_den_ff);
      s4_den_in     = {s3_den_ff, 1'b0};
   end

   // Valid bits of the front stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_vld_ff <= req_valid;
         end
         if (s2_load) begin
            s2_vld_ff <= s1_vld_ff;
         end
         if (s3_load) begin
            s3_vld_ff <= s2_vld_ff;
         end
         if (s4_load) begin
            s4_vld_ff <= s3_vld_ff;
         end
      end
   end

   // Payload of the front stages.
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_ok_ff  <= s1_ok_in;
         s1_val_ff <= s1_val_in;
         s1_wgt_ff <= s1_wgt_in;
      end
      if (s2_load) begin
         s2_ok_ff   <= s1_ok_ff;
         s2_prod_ff <= s2_prod_in;
         s2_den_ff  <= s2_den_in;
      end
      if (s3_load) begin
         s3_ok_ff  <= s2_ok_ff;
         s3_num_ff <= s3_num_in;
         s3_den_ff <= s2_den_ff;
      end
      if (s4_load) begin
         s4_tag_ff <= s4_tag_in;
         s4_num_ff <= s4_num_in;
         s4_den_ff <= s4_den_in;
      end
   end

   // Long division, one quotient bit per stage.
   nbsu_div #(
      .QUO_WIDTH (VALUE_WIDTH),
      .REM_WIDTH (REM_WIDTH),
      .DEN_WIDTH (DIV_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s4_vld_ff),
      .in_ready  (div_in_ready),
      .in_num    (s4_num_ff),
      .in_den    (s4_den_ff),
      .in_tag    (s4_tag_ff),
      .out_valid (div_out_valid),
      .out_ready (out_load),
      .out_quo   (div_quo),
      .out_tag   (div_tag)
   );

   // Output stage: restore the sign and clear results that are not valid.
   always_comb begin
      logic [VALUE_WIDTH-1:0] signed_quo;

      signed_quo = div_tag.neg ? (~div_quo + 1'b1) : div_quo;
      out_val_in = div_tag.ok ? $signed(signed_quo) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_load) begin
         out_vld_ff <= div_out_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_ok_ff  <= div_tag.ok;
         out_val_ff <= out_val_in;
      end
   end

   assign rsp_valid        = out_vld_ff;
   assign rsp_update_value = out_val_ff;
   assign rsp_update_valid = out_ok_ff;

   // An item off the boundary or without a full neighbor set always reports zero.
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_update_valid) |-> (rsp_update_value == '0))
      else $error("invalid result item carries a nonzero value");

   // An empty output register always takes the divider's item.
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      !out_vld_ff |-> out_load)
      else $error("output stage refused an item while empty");

   // An empty first stage always accepts a new item.
   a_in_free: assert property (@(posedge clock) disable iff (reset)
      !s1_vld_ff |-> req_ready)
      else $error("input refused with an empty first stage");

endmodule
